// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion shorthands used by the checker file acm_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/acm_pkg.sv =====
// ----------------------------------------------------------------------------
// acm_pkg
// shared types and constants of the accumulator machine execute block
// ----------------------------------------------------------------------------
package acm_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned PcW   = 8;
  localparam int unsigned AddrW = 8;
  localparam int unsigned OpW   = 4;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic [PcW-1:0]          pc_t;
  typedef logic [AddrW-1:0]        addr_t;

  typedef enum logic [OpW-1:0] {
    OP_LDA = 4'd0,
    OP_LDI = 4'd1,
    OP_STR = 4'd2,
    OP_XCH = 4'd3,
    OP_JMP = 4'd4,
    OP_JZS = 4'd5,
    OP_ADD = 4'd6,
    OP_SUB = 4'd7,
    OP_DEC = 4'd8,
    OP_HLT = 4'd9
  } op_t;

  localparam word_t WordMin = 16'sh8000;
  localparam word_t WordOne = 16'sh0001;

endpackage

// ===== hw/rtl/acm_stream_if.sv =====
// ----------------------------------------------------------------------------
// acm_stream_if
// valid/ready channels for instruction words and machine state words
// ----------------------------------------------------------------------------
interface acm_in_if;
  logic                 valid;
  logic                 ready;
  logic [3:0]           op;
  logic [7:0]           address;
  logic signed [15:0]   immediate;

  modport source (output valid, output op, output address, output immediate, input ready);
  modport sink   (input valid, input op, input address, input immediate, output ready);
endinterface

interface acm_out_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           next_pc;
  logic signed [15:0]   acc_out;
  logic signed [15:0]   data_out;
  logic                 zero_flag;
  logic                 halted;

  modport source (output valid, output next_pc, output acc_out, output data_out,
                  output zero_flag, output halted, input ready);
  modport sink   (input valid, input next_pc, input acc_out, input data_out,
                  input zero_flag, input halted, output ready);
endinterface

// ===== hw/rtl/acm_ram.sv =====
// ----------------------------------------------------------------------------
// acm_ram
// generic single-write single-read ram with registered read, read-first
// ----------------------------------------------------------------------------
module acm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/accumulator_machine_execute.sv =====
// ----------------------------------------------------------------------------
// accumulator_machine_execute
// execute stage of a 16-bit signed accumulator machine
// ----------------------------------------------------------------------------
// in_ch carries one decoded instruction word (op, address, immediate); out_ch
// returns one state word per instruction: pc, accumulator, data register,
// zero bit and halt flag as they stand after that instruction.
// an accepted instruction is registered in the execute stage while its data
// memory word is read, then executes and offers its state word once out_ch is free.
// throughput: one instruction per cycle while out_ch.ready stays high, set
// by the read/modify/write of the data memory, with a store forwarded to a
// load of the same word issued at the same edge.
// reset: registers clear, then the data memory is swept to zero, one word a
// cycle, covering all MEM_WORDS words; in_ch.ready stays low during the sweep.
// stall: while out_ch.ready is low the state word holds, one more
// instruction waits in the execute stage and in_ch.ready then drops.
// after a halt, further instructions are taken and return the held state.
// ----------------------------------------------------------------------------
module accumulator_machine_execute #(
  parameter int unsigned MEM_WORDS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  acm_in_if.sink    in_ch,
  acm_out_if.source out_ch
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [AW-1:0]   in_idx;
  logic            in_fire;
  logic            exec;

  logic            clr_active_r;
  logic [AW-1:0]   clr_cnt_r;

  logic            s1_valid_r;
  acm_pkg::op_t    s1_op_r;
  acm_pkg::addr_t  s1_addr_r;
  acm_pkg::word_t  s1_imm_r;
  logic [AW-1:0]   s1_idx_r;

  logic            fwd_hit_r;
  acm_pkg::word_t  fwd_data_r;

  acm_pkg::word_t  acc_r, acc_nxt;
  acm_pkg::word_t  dat_r, dat_nxt;
  logic            zero_r, zero_nxt;
  acm_pkg::pc_t    pc_r, pc_nxt;
  logic            halt_r, halt_nxt;
  logic            out_valid_r;

  logic            str_we;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [15:0]     ram_wdata;
  logic [15:0]     ram_rdata;
  acm_pkg::word_t  ld_data;
  acm_pkg::pc_t    pc_inc;
  logic signed [16:0] sum;
  logic signed [16:0] diff;

  // memory index is the address modulo the memory depth
  if (MEM_WORDS >= 256) begin : g_wide
    assign in_idx = AW'(in_ch.address);
  end else begin : g_narrow
    typedef logic [AW-1:0] idx_tab_t [256];

    function automatic idx_tab_t build_idx_tab();
      idx_tab_t t;
      int       r;
      for (int a = 0; a < 256; a++) begin
        r = a;
        while (r >= int'(MEM_WORDS)) begin
          r = r - int'(MEM_WORDS);
        end
        t[a] = AW'(r);
      end
      return t;
    endfunction

    localparam idx_tab_t IdxTab = build_idx_tab();
    assign in_idx = IdxTab[in_ch.address];
  end

  assign exec         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !clr_active_r && (!s1_valid_r || exec);
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.next_pc   = pc_r;
  assign out_ch.acc_out   = acc_r;
  assign out_ch.data_out  = dat_r;
  assign out_ch.zero_flag = zero_r;
  assign out_ch.halted    = halt_r;

  assign ld_data = fwd_hit_r ? fwd_data_r : acm_pkg::word_t'(ram_rdata);
  assign pc_inc  = pc_r + acm_pkg::pc_t'(1);
  assign sum     = {acc_r[15], acc_r} + {dat_r[15], dat_r};
  assign diff    = {acc_r[15], acc_r} - {dat_r[15], dat_r};
  assign str_we  = exec && !halt_r && (s1_op_r == acm_pkg::OP_STR);

  always_comb begin
    acc_nxt  = acc_r;
    dat_nxt  = dat_r;
    zero_nxt = zero_r;
    pc_nxt   = pc_r;
    halt_nxt = halt_r;
    if (!halt_r) begin
      unique case (s1_op_r)
        acm_pkg::OP_LDA: begin
          acc_nxt = ld_data;
          pc_nxt  = pc_inc;
        end
        acm_pkg::OP_LDI: begin
          acc_nxt = s1_imm_r;
          pc_nxt  = pc_inc;
        end
        acm_pkg::OP_STR: begin
          pc_nxt = pc_inc;
        end
        acm_pkg::OP_XCH: begin
          acc_nxt = dat_r;
          dat_nxt = acc_r;
          pc_nxt  = pc_inc;
        end
        acm_pkg::OP_JMP: begin
          pc_nxt = s1_addr_r;
        end
        acm_pkg::OP_JZS: begin
          pc_nxt = zero_r ? s1_addr_r : pc_inc;
        end
        acm_pkg::OP_ADD: begin
          // overflow leaves accumulator and zero bit alone
          if (sum[16] == sum[15]) begin
            acc_nxt  = sum[15:0];
            zero_nxt = (sum[15:0] == '0);
          end
          pc_nxt = pc_inc;
        end
        acm_pkg::OP_SUB: begin
          if (diff[16] == diff[15]) begin
            acc_nxt  = diff[15:0];
            zero_nxt = (diff[15:0] == '0);
          end
          pc_nxt = pc_inc;
        end
        acm_pkg::OP_DEC: begin
          // saturates at the most negative value
          if (acc_r != acm_pkg::WordMin) begin
            acc_nxt = acc_r - acm_pkg::WordOne;
          end
          zero_nxt = (acc_r == acm_pkg::WordOne);
          pc_nxt   = pc_inc;
        end
        acm_pkg::OP_HLT: begin
          halt_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (clr_active_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = str_we;
      ram_waddr = s1_idx_r;
      ram_wdata = acc_r;
    end
  end

  acm_ram #(
    .WIDTH (16),
    .DEPTH (MEM_WORDS)
  ) u_dmem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      s1_valid_r   <= 1'b0;
      fwd_hit_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      acc_r        <= '0;
      dat_r        <= '0;
      zero_r       <= 1'b0;
      pc_r         <= '0;
      halt_r       <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(MEM_WORDS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end

      if (in_fire) begin
        s1_valid_r <= 1'b1;
        // store to the word being read at this edge
        fwd_hit_r  <= str_we && (s1_idx_r == in_idx);
      end else if (exec) begin
        s1_valid_r <= 1'b0;
      end

      if (exec) begin
        out_valid_r <= 1'b1;
        acc_r       <= acc_nxt;
        dat_r       <= dat_nxt;
        zero_r      <= zero_nxt;
        pc_r        <= pc_nxt;
        halt_r      <= halt_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= acm_pkg::op_t'(in_ch.op);
      s1_addr_r  <= in_ch.address;
      s1_imm_r   <= in_ch.immediate;
      s1_idx_r   <= in_idx;
      fwd_data_r <= acc_r;
    end
  end

endmodule

// ===== hw/rtl/acm_checker.sv =====
// ----------------------------------------------------------------------------
// acm_checker
// port-level checks of the accumulator machine execute block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         next_pc,
  input logic signed [15:0] acc_out,
  input logic               halted
);

  // result word held until taken
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(acc_out))

  // memory sweep keeps the input closed right after reset
  `ASSERT_IMPLIES(a_sweep_closed, clk, rst_n, $rose(rst_n), !in_ready)

  // halt is sticky
  `ASSERT_NEXT(a_halt_sticky, clk, rst_n, out_valid && halted, halted)

  // pc frozen once halted
  `ASSERT_NEXT(a_halt_pc, clk, rst_n, out_valid && halted, $stable(next_pc))

endmodule

bind accumulator_machine_execute acm_checker u_acm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .next_pc   (out_ch.next_pc),
  .acc_out   (out_ch.acc_out),
  .halted    (out_ch.halted)
);
